[sv/sbvs_pkg.sv]
// ----------------------------------------------------------------------------
// sbvs_pkg - shared types for single-bone vertex skinning
// Word formats of both channels, palette access groups and fixed constants.
// ----------------------------------------------------------------------------
package sbvs_pkg;

    localparam int ELEMS_PER_BONE = 12;
    localparam int BONE_W         = 6;
    localparam int ELEM_W         = 4;
    localparam int DATA_W         = 32;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int FRAC_W         = 16;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_SKIN = 1'b1;

    typedef logic [ELEMS_PER_BONE-1:0][DATA_W-1:0] mat_t;
    typedef logic [2:0][DATA_W-1:0]                vec3_t;

    typedef struct packed {
        logic                     action;
        logic [BONE_W-1:0]        bone_index;
        logic [ELEM_W-1:0]        matrix_element;
        logic signed [DATA_W-1:0] matrix_value;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] norm_x;
        logic signed [DATA_W-1:0] norm_y;
        logic signed [DATA_W-1:0] norm_z;
        logic [63:0]              tex_coords;
        logic                     last_vertex;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_pos_x;
        logic signed [DATA_W-1:0] out_pos_y;
        logic signed [DATA_W-1:0] out_pos_z;
        logic signed [DATA_W-1:0] out_norm_x;
        logic signed [DATA_W-1:0] out_norm_y;
        logic signed [DATA_W-1:0] out_norm_z;
        logic [63:0]              out_tex_coords;
        logic                     out_last;
    } out_word_t;

    typedef struct packed {
        logic              en;
        logic [BONE_W-1:0] bone;
        logic [ELEM_W-1:0] elem;
        logic [DATA_W-1:0] value;
    } pal_wr_t;

    typedef struct packed {
        logic              en;
        logic [BONE_W-1:0] bone;
    } pal_rd_t;

endpackage

[sv/sbvs_palette.sv]
// ----------------------------------------------------------------------------
// sbvs_palette - bone matrix palette
// Twelve banks, one per matrix element, so a whole matrix is read in a single registered access.
// ----------------------------------------------------------------------------
module sbvs_palette #(
    parameter int NUM_BONES = 64
) (
    input  logic             aclk,
    input  sbvs_pkg::pal_wr_t wr,
    input  sbvs_pkg::pal_rd_t rd,
    output sbvs_pkg::mat_t    rdata
);
    import sbvs_pkg::*;

    localparam int IDX_W = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

    logic             wr_ok;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    // drop loads to a bone outside the palette or to an unused element
    assign wr_ok   = wr.en && (32'(wr.bone) < NUM_BONES) && (32'(wr.elem) < ELEMS_PER_BONE);
    assign wr_addr = IDX_W'(wr.bone);
    assign rd_addr = IDX_W'(rd.bone);

    for (genvar e = 0; e < ELEMS_PER_BONE; e++) begin : g_bank
        logic [DATA_W-1:0] mem [NUM_BONES];
        logic [DATA_W-1:0] rdata_reg;

        always_ff @(posedge aclk) begin
            if (wr_ok && (32'(wr.elem) == e)) begin
                mem[wr_addr] <= wr.value;
            end
        end

        always_ff @(posedge aclk) begin
            if (rd.en) begin
                rdata_reg <= mem[rd_addr];
            end
        end

        assign rdata[e] = rdata_reg;
    end

endmodule

[sv/sbvs_dot3.sv]
// ----------------------------------------------------------------------------
// sbvs_dot3 - three-term Q16.16 dot product with offset
// Multiply, pairwise add, final add with floor and saturation: three stages.
// ----------------------------------------------------------------------------
module sbvs_dot3 (
    input  logic                      aclk,
    input  logic                      en,
    input  sbvs_pkg::vec3_t           vec,
    input  sbvs_pkg::vec3_t           col,
    input  logic [sbvs_pkg::DATA_W-1:0] offset,
    output logic [sbvs_pkg::DATA_W-1:0] result
);
    import sbvs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [DATA_W-1:0] offset_reg;
    logic signed [SUM_W-1:0]  sum_a_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-FRAC_W-1:0] shifted;
    logic [SUM_W-FRAC_W-DATA_W:0]   top_bits;
    logic [DATA_W-1:0]        result_next;
    logic [DATA_W-1:0]        result_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= $signed(vec[k]) * $signed(col[k]);
            end
            offset_reg <= $signed(offset);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_a_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
            sum_b_reg <= SUM_W'(prod_reg[2]) + (SUM_W'(offset_reg) <<< FRAC_W);
        end
    end

    // floor to Q16.16, then clamp when the upper bits are not pure sign
    always_comb begin
        total    = sum_a_reg + sum_b_reg;
        shifted  = (SUM_W-FRAC_W)'(total >>> FRAC_W);
        top_bits = shifted[SUM_W-FRAC_W-1:DATA_W-1];
        if ((top_bits == '0) || (top_bits == '1)) begin
            result_next = shifted[DATA_W-1:0];
        end else if (shifted[SUM_W-FRAC_W-1]) begin
            result_next = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            result_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[sv/single_bone_vertex_skinning.sv]
// ----------------------------------------------------------------------------
// single_bone_vertex_skinning - one-bone vertex skinning in Q16.16
// Palette of affine bone matrices; transforms position and normal per vertex.
// ----------------------------------------------------------------------------
// A load word writes one matrix element (row*3 + column) of one bone and
// gives no result; loads to an element code above 11 or a bone at or above
// NUM_BONES are dropped. A skin word gives one result word: position times
// the full 4x3 matrix, normal times its upper 3x3, each summed exactly,
// floored to Q16.16 and saturated, with texture coordinates and the last
// mark copied. A bone outside the palette yields zero position and normal.
// The block takes one word every cycle while the output is not stalled. A
// vertex result passes the palette read, registered at the edge that accepts
// its word, then each dot-product unit adds three more stages (multiply,
// pairwise add, final add with saturation), four register stages in all.
// A load followed at once by a vertex of the same bone
// sees the new value. When m_ready is low with a result waiting, the whole
// pipeline holds and s_ready drops; nothing is lost or repeated. The palette
// has no reset: read only elements that were loaded.
// ----------------------------------------------------------------------------
module single_bone_vertex_skinning #(
    parameter int NUM_BONES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbvs_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbvs_pkg::out_word_t m_data
);
    import sbvs_pkg::*;

    // one enable for every stage: advance unless a result is stuck at the end
    logic    advance;
    logic    accept;
    pal_wr_t pal_wr;
    pal_rd_t pal_rd;
    mat_t    mat;
    mat_t    mat_used;

    logic [3:0] valid_reg;
    logic [3:0] valid_next;

    // stage 1 payload, aligned with the palette read data, plus the texture and last-mark delay lines
    logic        bone_ok_reg;
    vec3_t       pos_reg;
    vec3_t       norm_reg;
    logic [63:0] tex_reg  [4];
    logic        last_reg [4];

    vec3_t             col [3];
    logic [DATA_W-1:0] pos_out  [3];
    logic [DATA_W-1:0] norm_out [3];

    assign advance = !valid_reg[3] || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    assign pal_wr.en    = accept && (s_data.action == ACTION_LOAD);
    assign pal_wr.bone  = s_data.bone_index;
    assign pal_wr.elem  = s_data.matrix_element;
    assign pal_wr.value = s_data.matrix_value;
    assign pal_rd.en    = advance;
    assign pal_rd.bone  = s_data.bone_index;

    sbvs_palette #(
        .NUM_BONES(NUM_BONES)
    ) u_palette (
        .aclk (aclk),
        .wr   (pal_wr),
        .rd   (pal_rd),
        .rdata(mat)
    );

    // shift valid bits along; only skin words enter the pipeline
    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = {valid_reg[2:0], accept && (s_data.action == ACTION_SKIN)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bone_ok_reg <= 32'(s_data.bone_index) < NUM_BONES;
            pos_reg     <= {s_data.pos_z, s_data.pos_y, s_data.pos_x};
            norm_reg    <= {s_data.norm_z, s_data.norm_y, s_data.norm_x};
            tex_reg[0]  <= s_data.tex_coords;
            last_reg[0] <= s_data.last_vertex;
            for (int s = 1; s < 4; s++) begin
                tex_reg[s]  <= tex_reg[s-1];
                last_reg[s] <= last_reg[s-1];
            end
        end
    end

    // zero the matrix for a bone outside the palette
    assign mat_used = bone_ok_reg ? mat : '0;

    for (genvar j = 0; j < 3; j++) begin : g_comp
        assign col[j] = {mat_used[6+j], mat_used[3+j], mat_used[j]};

        sbvs_dot3 u_pos (
            .aclk  (aclk),
            .en    (advance),
            .vec   (pos_reg),
            .col   (col[j]),
            .offset(mat_used[9+j]),
            .result(pos_out[j])
        );

        sbvs_dot3 u_norm (
            .aclk  (aclk),
            .en    (advance),
            .vec   (norm_reg),
            .col   (col[j]),
            .offset('0),
            .result(norm_out[j])
        );
    end

    assign m_valid               = valid_reg[3];
    assign m_data.out_pos_x      = pos_out[0];
    assign m_data.out_pos_y      = pos_out[1];
    assign m_data.out_pos_z      = pos_out[2];
    assign m_data.out_norm_x     = norm_out[0];
    assign m_data.out_norm_y     = norm_out[1];
    assign m_data.out_norm_z     = norm_out[2];
    assign m_data.out_tex_coords = tex_reg[3];
    assign m_data.out_last       = last_reg[3];

endmodule
